// ----- rtl/core/tpc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the timestamp playback cursor
// no dependencies

package tpc_pkg;

   localparam int OP_WIDTH          = 3;
   localparam int PORT_TIME_WIDTH   = 32;
   localparam int FRAME_INDEX_WIDTH = 10;
   localparam int SPEED_WIDTH       = 16;
   localparam int SPEED_FRAC        = 8;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 16;

   localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 16'd256;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOOP  = 1'd1;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_PLAY   = 3'd2,
      OP_PAUSE  = 3'd3,
      OP_STOP   = 3'd4,
      OP_SEEK   = 3'd5,
      OP_TICK   = 3'd6
   } op_type;

endpackage

// ----- rtl/core/tpc_if.sv -----
`timescale 1ns / 1ps
// command and result channel interfaces for the timestamp playback cursor
// depends on tpc_pkg

interface tpc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [tpc_pkg::OP_WIDTH-1:0]         op;
   logic [tpc_pkg::PORT_TIME_WIDTH-1:0]  time_value;

   modport source (output valid, output op, output time_value, input ready);
   modport sink   (input valid, input op, input time_value, output ready);
endinterface

interface tpc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [tpc_pkg::PORT_TIME_WIDTH-1:0]    current_time;
   logic [tpc_pkg::FRAME_INDEX_WIDTH-1:0]  frame_index;
   logic                                   is_playing;
   logic                                   is_paused;
   logic                                   is_finished;
   logic                                   has_entries;
   logic                                   table_full;

   modport source (output valid, output current_time, output frame_index,
                   output is_playing, output is_paused, output is_finished,
                   output has_entries, output table_full, input ready);
   modport sink   (input valid, input current_time, input frame_index,
                   input is_playing, input is_paused, input is_finished,
                   input has_entries, input table_full, output ready);
endinterface

// ----- rtl/core/timestamp_playback_cursor_unit.sv -----
`timescale 1ns / 1ps
// timestamp playback cursor: timestamp table, position, frame index and play flags
// depends on tpc_pkg and the channel interfaces in tpc_if

// Takes one command transaction at a time and returns one result transaction
// per command. Clear, append, play, pause, stop and unused codes go from
// acceptance straight to the result register. A seek or a tick also scans
// the table, and a tick whose position wraps in loop mode first forms the
// wrap remainder: the frame index is found by scanning the timestamp table
// one entry per cycle through its single read port, and the wrap remainder
// is formed one bit per cycle on the shared subtractor. A new command is
// accepted while the previous result still waits at the output register. The
// table needs no clearing after reset. The user is to write playback_speed and
// loop_enable through the csr port while the block is idle; it is not enforced.

module timestamp_playback_cursor_unit #(
   parameter int TABLE_DEPTH = 1024,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tpc_req_if.sink                              req_chan,
   tpc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [tpc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tpc_pkg::CSR_DATA_WIDTH-1:0]   csr_wr_data
);

   localparam int TW = TIME_WIDTH;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = TW + tpc_pkg::SPEED_WIDTH;
   localparam int SW = PW - tpc_pkg::SPEED_FRAC;
   localparam int AW = SW + 1;
   localparam int BW = $clog2(TW);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEEK_HI,
      ST_SEEK_LO,
      ST_MUL,
      ST_ADD,
      ST_TICK_HI,
      ST_SPAN,
      ST_OFFSET,
      ST_DIV,
      ST_WRAP,
      ST_SCAN,
      ST_DONE
   } state_type;

   // timestamp table
   logic [TW-1:0] ts_mem [TABLE_DEPTH];
   logic [TW-1:0] rd_data_ff;
   logic          mem_we;

   state_type state_ff, state_in;
   logic [TW-1:0] pos_ff, pos_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          play_ff, play_in;
   logic          pause_ff, pause_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] first_ff, first_in;
   logic [TW-1:0] last_ff, last_in;
   logic [tpc_pkg::SPEED_WIDTH-1:0] speed_ff, speed_in;
   logic          loop_ff, loop_in;
   logic          drop_ff, drop_in;
   logic [TW-1:0] tv_ff, tv_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [TW-1:0] work_ff, work_in;
   logic [TW-1:0] span_ff, span_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [CW-1:0] scan_addr_ff, scan_addr_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          pend_ff, pend_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [tpc_pkg::PORT_TIME_WIDTH-1:0]    rsp_time_ff, rsp_time_in;
   logic [tpc_pkg::FRAME_INDEX_WIDTH-1:0]  rsp_index_ff, rsp_index_in;
   logic rsp_play_ff, rsp_play_in;
   logic rsp_pause_ff, rsp_pause_in;
   logic rsp_fin_ff, rsp_fin_in;
   logic rsp_has_ff, rsp_has_in;
   logic rsp_full_ff, rsp_full_in;

   logic          req_acc;
   logic [TW-1:0] tv_req;
   logic          have;
   logic          tbl_full;

   // shared subtract / compare unit
   logic [TW:0]   alu_a, alu_b;
   logic [TW+1:0] alu_diff;
   logic          alu_borrow;

   // shared adder
   logic [SW-1:0] add_a, add_b;
   logic [AW-1:0] add_sum;
   logic          add_sat;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign tv_req         = TW'(req_chan.time_value);
   assign have           = (cnt_ff != '0);
   assign tbl_full       = (cnt_ff == CW'(TABLE_DEPTH));

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.current_time = rsp_time_ff;
   assign rsp_chan.frame_index  = rsp_index_ff;
   assign rsp_chan.is_playing   = rsp_play_ff;
   assign rsp_chan.is_paused    = rsp_pause_ff;
   assign rsp_chan.is_finished  = rsp_fin_ff;
   assign rsp_chan.has_entries  = rsp_has_ff;
   assign rsp_chan.table_full   = rsp_full_ff;

   always_comb begin
      case (state_ff)
         ST_SEEK_HI: begin
            alu_a = {1'b0, tv_ff};
            alu_b = {1'b0, last_ff};
         end
         ST_SEEK_LO: begin
            alu_a = {1'b0, work_ff};
            alu_b = {1'b0, first_ff};
         end
         ST_TICK_HI: begin
            alu_a = {1'b0, last_ff};
            alu_b = {1'b0, work_ff};
         end
         ST_SPAN: begin
            alu_a = {1'b0, last_ff};
            alu_b = {1'b0, first_ff};
         end
         ST_OFFSET: begin
            alu_a = {1'b0, work_ff};
            alu_b = {1'b0, first_ff};
         end
         ST_DIV: begin
            alu_a = {rem_ff, work_ff[TW-1]};
            alu_b = {1'b0, span_ff};
         end
         ST_SCAN: begin
            alu_a = {1'b0, pos_ff};
            alu_b = {1'b0, rd_data_ff};
         end
         default: begin
            alu_a = {1'b0, pos_ff};
            alu_b = {1'b0, last_ff};
         end
      endcase
   end

   assign alu_diff   = (TW+2)'(alu_a) - (TW+2)'(alu_b);
   assign alu_borrow = alu_diff[TW+1];

   always_comb begin
      if (state_ff == ST_WRAP) begin
         add_a = SW'(first_ff);
         add_b = SW'(rem_ff);
      end else begin
         add_a = SW'(pos_ff);
         add_b = prod_ff[PW-1:tpc_pkg::SPEED_FRAC];
      end
   end

   assign add_sum = AW'(add_a) + AW'(add_b);
   assign add_sat = |add_sum[AW-1:TW];

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      play_in      = play_ff;
      pause_in     = pause_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      drop_in      = drop_ff;
      tv_in        = tv_ff;
      prod_in      = prod_ff;
      work_in      = work_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      scan_addr_in = scan_addr_ff;
      cmp_idx_in   = cmp_idx_ff;
      pend_in      = pend_ff;
      mem_we       = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_time_in  = rsp_time_ff;
      rsp_index_in = rsp_index_ff;
      rsp_play_in  = rsp_play_ff;
      rsp_pause_in = rsp_pause_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_full_in  = rsp_full_ff;

      speed_in = (csr_wr_en && csr_index == tpc_pkg::CSR_SPEED) ? csr_wr_data : speed_ff;
      loop_in  = (csr_wr_en && csr_index == tpc_pkg::CSR_LOOP) ? csr_wr_data[0] : loop_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               tv_in    = tv_req;
               drop_in  = 1'b0;
               state_in = ST_DONE;
               case (tpc_pkg::op_type'(req_chan.op))
                  tpc_pkg::OP_CLEAR: begin
                     cnt_in   = '0;
                     pos_in   = '0;
                     idx_in   = '0;
                     play_in  = 1'b0;
                     pause_in = 1'b0;
                  end
                  tpc_pkg::OP_APPEND: begin
                     if (tbl_full) begin
                        drop_in = 1'b1;
                     end else begin
                        mem_we  = 1'b1;
                        cnt_in  = cnt_ff + CW'(1);
                        last_in = tv_req;
                        if (!have) begin
                           first_in = tv_req;
                        end
                     end
                  end
                  tpc_pkg::OP_PLAY: begin
                     if (have) begin
                        play_in  = 1'b1;
                        pause_in = 1'b0;
                        if (!pause_ff) begin
                           idx_in = '0;
                           pos_in = first_ff;
                        end
                     end
                  end
                  tpc_pkg::OP_PAUSE: begin
                     if (play_ff) begin
                        play_in  = 1'b0;
                        pause_in = 1'b1;
                     end
                  end
                  tpc_pkg::OP_STOP: begin
                     play_in  = 1'b0;
                     pause_in = 1'b0;
                     idx_in   = '0;
                     pos_in   = have ? first_ff : '0;
                  end
                  tpc_pkg::OP_SEEK: begin
                     if (have) begin
                        state_in = ST_SEEK_HI;
                     end
                  end
                  tpc_pkg::OP_TICK: begin
                     if (have && play_ff) begin
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEEK_HI: begin
            work_in  = alu_borrow ? tv_ff : last_ff;
            state_in = ST_SEEK_LO;
         end
         ST_SEEK_LO: begin
            pos_in       = alu_borrow ? first_ff : work_ff;
            idx_in       = '0;
            scan_addr_in = '0;
            pend_in      = 1'b0;
            state_in     = ST_SCAN;
         end
         ST_MUL: begin
            prod_in  = PW'(tv_ff) * PW'(speed_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            work_in  = add_sat ? '1 : add_sum[TW-1:0];
            state_in = ST_TICK_HI;
         end
         ST_TICK_HI: begin
            idx_in       = '0;
            scan_addr_in = '0;
            pend_in      = 1'b0;
            if (!alu_borrow) begin
               pos_in   = work_ff;
               state_in = ST_SCAN;
            end else if (!loop_ff) begin
               pos_in   = last_ff;
               play_in  = 1'b0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            if (alu_borrow || alu_diff == '0) begin
               pos_in   = first_ff;
               state_in = ST_SCAN;
            end else begin
               span_in  = alu_diff[TW-1:0];
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            if (alu_borrow) begin
               pos_in   = first_ff;
               state_in = ST_SCAN;
            end else begin
               work_in  = alu_diff[TW-1:0];
               rem_in   = '0;
               bit_in   = BW'(TW - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = alu_borrow ? alu_a[TW-1:0] : alu_diff[TW-1:0];
            work_in = {work_ff[TW-2:0], 1'b0};
            bit_in  = bit_ff - BW'(1);
            if (bit_ff == '0) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            pos_in   = add_sum[TW-1:0];
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_addr_ff < cnt_ff) begin
               pend_in      = 1'b1;
               cmp_idx_in   = scan_addr_ff[IW-1:0];
               scan_addr_in = scan_addr_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (alu_borrow) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = cmp_idx_ff;
                  if (CW'(cmp_idx_ff) + CW'(1) == cnt_ff) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = tpc_pkg::PORT_TIME_WIDTH'(pos_ff);
               rsp_index_in = tpc_pkg::FRAME_INDEX_WIDTH'(idx_ff);
               rsp_play_in  = play_ff;
               rsp_pause_in = pause_ff;
               rsp_fin_in   = !have || (!play_ff && !pause_ff && !alu_borrow);
               rsp_has_in   = have;
               rsp_full_in  = drop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ts_mem[cnt_ff[IW-1:0]] <= tv_req;
      end
      rd_data_ff <= ts_mem[scan_addr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         idx_ff       <= '0;
         play_ff      <= 1'b0;
         pause_ff     <= 1'b0;
         cnt_ff       <= '0;
         speed_ff     <= tpc_pkg::SPEED_RESET;
         loop_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         play_ff      <= play_in;
         pause_ff     <= pause_in;
         cnt_ff       <= cnt_in;
         speed_ff     <= speed_in;
         loop_ff      <= loop_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff     <= first_in;
      last_ff      <= last_in;
      drop_ff      <= drop_in;
      tv_ff        <= tv_in;
      prod_ff      <= prod_in;
      work_ff      <= work_in;
      span_ff      <= span_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_index_ff <= rsp_index_in;
      rsp_play_ff  <= rsp_play_in;
      rsp_pause_ff <= rsp_pause_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_full_ff  <= rsp_full_in;
   end

endmodule

// ----- rtl/core/tpc_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the timestamp playback cursor, bound to the top level
// depends on tpc_pkg and timestamp_playback_cursor_unit

module tpc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [tpc_pkg::PORT_TIME_WIDTH-1:0]    current_time,
   input logic [tpc_pkg::FRAME_INDEX_WIDTH-1:0]  frame_index,
   input logic                                   is_playing,
   input logic                                   is_paused,
   input logic                                   is_finished,
   input logic                                   has_entries,
   input logic                                   table_full
);

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(current_time) &&
                                  $stable(frame_index))
      else $error("result changed while stalled");

   // playing and paused never together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(is_playing && is_paused))
      else $error("playing and paused both set");

   // empty table leaves the cursor at rest
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_entries |-> current_time == '0 && frame_index == '0 &&
                                    !is_playing && !is_paused && is_finished)
      else $error("empty table with cursor not at rest");

   // a dropped append means the table holds entries
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && table_full |-> has_entries && !is_finished || has_entries)
      else $error("dropped append on empty table");

endmodule

bind timestamp_playback_cursor_unit tpc_checker u_tpc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .current_time (rsp_chan.current_time),
   .frame_index  (rsp_chan.frame_index),
   .is_playing   (rsp_chan.is_playing),
   .is_paused    (rsp_chan.is_paused),
   .is_finished  (rsp_chan.is_finished),
   .has_entries  (rsp_chan.has_entries),
   .table_full   (rsp_chan.table_full)
);

// ----- tb/tpc_cursor_checker.sv -----
`timescale 1ns / 1ps
// checker for the timestamp playback cursor: tracks the cursor state from the
// observed command, result and csr traffic and compares every result transaction
// depends on tpc_pkg and the channel interfaces in tpc_if

module tpc_cursor_checker #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tpc_req_if                                   req_mon,
   tpc_rsp_if                                   rsp_mon,
   input  logic                                 csr_wr_en,
   input  logic [tpc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tpc_pkg::CSR_DATA_WIDTH-1:0]   csr_wr_data,
   output int unsigned                          fail_count,
   output int unsigned                          outstanding
);

   localparam int COUNT_WIDTH   = $clog2(TABLE_DEPTH) + 1;
   localparam int ADVANCE_WIDTH = tpc_pkg::PORT_TIME_WIDTH + tpc_pkg::SPEED_WIDTH;
   localparam int PRINT_LIMIT   = 200;
   localparam logic [tpc_pkg::PORT_TIME_WIDTH-1:0] TIME_ALL_ONES = '1;

   typedef struct packed {
      logic [tpc_pkg::PORT_TIME_WIDTH-1:0]   current_time;
      logic [tpc_pkg::FRAME_INDEX_WIDTH-1:0] frame_index;
      logic                                  is_playing;
      logic                                  is_paused;
      logic                                  is_finished;
      logic                                  has_entries;
      logic                                  table_full;
   } cursor_result_type;

   logic [tpc_pkg::PORT_TIME_WIDTH-1:0]   stamps [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0]                entry_count;
   logic [tpc_pkg::PORT_TIME_WIDTH-1:0]   position;
   logic [tpc_pkg::FRAME_INDEX_WIDTH-1:0] cursor;
   logic                                  playing;
   logic                                  paused;
   logic [tpc_pkg::SPEED_WIDTH-1:0]       speed;
   logic                                  loop_en;
   cursor_result_type                     expected_results [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // last entry of the leading run not above the position
   task automatic locate_frame();
      int i;
      cursor = '0;
      for (i = 0; i < int'(entry_count); i++) begin
         if (stamps[i] > position)
            break;
         cursor = tpc_pkg::FRAME_INDEX_WIDTH'(i);
      end
   endtask

   task automatic apply_command(input logic [tpc_pkg::OP_WIDTH-1:0] op,
                                input logic [tpc_pkg::PORT_TIME_WIDTH-1:0] tv,
                                output cursor_result_type r);
      logic [tpc_pkg::PORT_TIME_WIDTH-1:0] lo;
      logic [tpc_pkg::PORT_TIME_WIDTH-1:0] hi;
      logic [tpc_pkg::PORT_TIME_WIDTH-1:0] t;
      logic [ADVANCE_WIDTH-1:0]            advance;
      logic                                had;
      logic                                dropped;
      had     = entry_count != 0;
      dropped = 1'b0;
      lo      = '0;
      hi      = '0;
      if (had) begin
         lo = stamps[0];
         hi = stamps[entry_count - 1'b1];
      end
      case (op)
         tpc_pkg::OP_CLEAR: begin
            entry_count = '0;
            position    = '0;
            cursor      = '0;
            playing     = 1'b0;
            paused      = 1'b0;
         end
         tpc_pkg::OP_APPEND: begin
            if (entry_count >= TABLE_DEPTH) begin
               dropped = 1'b1;
            end else begin
               stamps[entry_count] = tv;
               entry_count = entry_count + 1'b1;
            end
         end
         tpc_pkg::OP_PLAY: begin
            if (had) begin
               if (!paused) begin
                  cursor   = '0;
                  position = lo;
               end
               playing = 1'b1;
               paused  = 1'b0;
            end
         end
         tpc_pkg::OP_PAUSE: begin
            if (playing) begin
               playing = 1'b0;
               paused  = 1'b1;
            end
         end
         tpc_pkg::OP_STOP: begin
            playing  = 1'b0;
            paused   = 1'b0;
            cursor   = '0;
            position = lo;
         end
         tpc_pkg::OP_SEEK: begin
            if (had) begin
               t = (tv < hi) ? tv : hi;
               position = (t > lo) ? t : lo;
               locate_frame();
            end
         end
         tpc_pkg::OP_TICK: begin
            if (had && playing) begin
               advance = ADVANCE_WIDTH'(tv) * ADVANCE_WIDTH'(speed);
               advance = advance >> tpc_pkg::SPEED_FRAC;
               if (advance > ADVANCE_WIDTH'(TIME_ALL_ONES - position))
                  t = TIME_ALL_ONES;
               else
                  t = position + advance[tpc_pkg::PORT_TIME_WIDTH-1:0];
               if (t > hi) begin
                  if (!loop_en) begin
                     t       = hi;
                     playing = 1'b0;
                  end else if (hi > lo && t >= lo) begin
                     t = lo + (t - lo) % (hi - lo);
                  end else begin
                     t = lo;
                  end
               end
               position = t;
               locate_frame();
            end
         end
         default: ;
      endcase
      r.current_time = position;
      r.frame_index  = cursor;
      r.is_playing   = playing;
      r.is_paused    = paused;
      r.has_entries  = entry_count != 0;
      r.table_full   = dropped;
      r.is_finished  = 1'b1;
      if (entry_count != 0)
         r.is_finished = !playing && !paused && position >= stamps[entry_count - 1'b1];
   endtask

   always @(posedge clock) begin : observe
      cursor_result_type want;
      if (reset) begin
         entry_count = '0;
         position    = '0;
         cursor      = '0;
         playing     = 1'b0;
         paused      = 1'b0;
         speed       = tpc_pkg::SPEED_RESET;
         loop_en     = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               tpc_pkg::CSR_SPEED: speed   = csr_wr_data[tpc_pkg::SPEED_WIDTH-1:0];
               tpc_pkg::CSR_LOOP:  loop_en = csr_wr_data[0];
               default: ;
            endcase
         end
         // results first, so a result never matches a command taken at the same edge
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no command pending", rsp_mon.current_time, '0);
            end else begin
               want = expected_results.pop_front();
               compare_field("current_time", rsp_mon.current_time, want.current_time);
               compare_field("frame_index", 32'(rsp_mon.frame_index), 32'(want.frame_index));
               compare_field("is_playing", 32'(rsp_mon.is_playing), 32'(want.is_playing));
               compare_field("is_paused", 32'(rsp_mon.is_paused), 32'(want.is_paused));
               compare_field("is_finished", 32'(rsp_mon.is_finished), 32'(want.is_finished));
               compare_field("has_entries", 32'(rsp_mon.has_entries), 32'(want.has_entries));
               compare_field("table_full", 32'(rsp_mon.table_full), 32'(want.table_full));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            apply_command(req_mon.op, req_mon.time_value, want);
            expected_results.insert(expected_results.size(), want);
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

// ----- tb/timestamp_playback_cursor_unit_tb.sv -----
`timescale 1ns / 1ps
// testbench top for the timestamp playback cursor: clock, reset, command and csr
// stimulus with random idling, verdict from the checker's failure count
// depends on tpc_pkg, tpc_if, timestamp_playback_cursor_unit and tpc_cursor_checker

module timestamp_playback_cursor_unit_tb;

   localparam int TABLE_DEPTH = 1024;
   localparam int TIME_WIDTH  = 32;
   localparam int PHASES      = 8;
   localparam logic [tpc_pkg::OP_WIDTH-1:0] OP_RESERVED = 3'd7;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_wr_en;
   logic [tpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [tpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data;
   int unsigned                         fail_count;
   int unsigned                         outstanding;
   bit                                  calm_phase = 1'b0;

   tpc_req_if req_if ();
   tpc_rsp_if rsp_if ();

   timestamp_playback_cursor_unit #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tpc_cursor_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) cursor_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] stamp_gap();
      if ($urandom_range(0, 5) == 0)
         return '0;
      return $urandom_range(1, 32'h0000_c000);
   endfunction

   function automatic logic [31:0] tick_delta();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 32'h0000_0800);
         1:       return $urandom_range(0, 32'h0000_8000);
         2:       return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned table_size();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(1, 3);
      return $urandom_range(2, 40);
   endfunction

   task automatic send_cmd(input logic [tpc_pkg::OP_WIDTH-1:0] op, input logic [31:0] tv);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.op         <= op;
      req_if.time_value <= tv;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // hold off commands until every result transaction is back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_regs(input logic [tpc_pkg::SPEED_WIDTH-1:0] speed,
                             input logic loop_en);
      csr_wr_en   <= 1'b1;
      csr_index   <= tpc_pkg::CSR_SPEED;
      csr_wr_data <= tpc_pkg::CSR_DATA_WIDTH'(speed);
      @(posedge clock);
      csr_index   <= tpc_pkg::CSR_LOOP;
      csr_wr_data <= tpc_pkg::CSR_DATA_WIDTH'(loop_en);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic load_table(input int unsigned n_stamps, output logic [31:0] first_ts,
                             output logic [31:0] last_ts);
      logic [31:0] stamp;
      if ($urandom_range(0, 3) == 0)
         stamp = $urandom;
      else
         stamp = $urandom_range(0, 32'h0008_0000);
      first_ts = stamp;
      last_ts  = stamp;
      send_cmd(tpc_pkg::OP_CLEAR, $urandom);
      repeat (n_stamps) begin
         send_cmd(tpc_pkg::OP_APPEND, stamp);
         last_ts = stamp;
         stamp   = stamp + stamp_gap();
      end
   endtask

   // well-formed load and play, then a random command mix that may reload the table
   task automatic play_session(input int unsigned n_items);
      int unsigned sent;
      int unsigned pick;
      logic [31:0] first_ts;
      logic [31:0] last_ts;
      load_table(table_size(), first_ts, last_ts);
      send_cmd(tpc_pkg::OP_PLAY, $urandom);
      sent = 2;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         sent++;
         if (pick < 40 || pick >= 91) begin
            send_cmd(tpc_pkg::OP_TICK, tick_delta());
         end else if (pick < 52) begin
            if ($urandom_range(0, 1) == 0)
               send_cmd(tpc_pkg::OP_SEEK, $urandom);
            else
               send_cmd(tpc_pkg::OP_SEEK, $urandom_range(first_ts, last_ts));
         end else if (pick < 67) begin
            send_cmd(tpc_pkg::OP_PLAY, $urandom);
         end else if (pick < 74) begin
            send_cmd(tpc_pkg::OP_PAUSE, $urandom);
         end else if (pick < 77) begin
            send_cmd(tpc_pkg::OP_STOP, $urandom);
         end else if (pick < 85) begin
            if ($urandom_range(0, 3) == 0)
               last_ts = $urandom;
            else
               last_ts = last_ts + stamp_gap();
            send_cmd(tpc_pkg::OP_APPEND, last_ts);
         end else if (pick < 87) begin
            load_table(table_size(), first_ts, last_ts);
         end else if (pick < 90) begin
            send_cmd(OP_RESERVED, $urandom);
            sent--;
         end else begin
            drain();
            sent--;
         end
      end
   endtask

   initial begin : result_ready_drive
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(40, 200)) @(posedge clock);
         else
            repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm_phase && $urandom_range(0, 2) != 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [tpc_pkg::CSR_DATA_WIDTH-1:0] speed_plan [PHASES];
      bit [PHASES-1:0]                    loop_plan;
      logic [31:0]                        stamp;
      int                                 ph;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= tpc_pkg::CSR_SPEED;
      csr_wr_data       <= '0;
      req_if.valid      <= 1'b0;
      req_if.op         <= tpc_pkg::OP_CLEAR;
      req_if.time_value <= '0;
      speed_plan = '{16'd256, 16'd256, 16'd0, 16'hffff, 16'd1,
                     16'($urandom), 16'hffff, 16'($urandom)};
      loop_plan  = 8'b1101_0110;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then short tables, one out of order, under reset settings
      send_cmd(tpc_pkg::OP_TICK, 32'h0001_0000);
      send_cmd(tpc_pkg::OP_PLAY, '0);
      send_cmd(tpc_pkg::OP_SEEK, 32'h0000_8000);
      send_cmd(tpc_pkg::OP_PAUSE, '0);
      send_cmd(tpc_pkg::OP_STOP, '1);
      send_cmd(OP_RESERVED, '1);
      send_cmd(tpc_pkg::OP_APPEND, 32'h0001_0000);
      send_cmd(tpc_pkg::OP_APPEND, 32'h0001_8000);
      send_cmd(tpc_pkg::OP_APPEND, 32'h0004_0000);
      send_cmd(tpc_pkg::OP_PAUSE, '0);
      send_cmd(tpc_pkg::OP_PLAY, '0);
      send_cmd(tpc_pkg::OP_TICK, 32'h0000_c000);
      send_cmd(tpc_pkg::OP_PAUSE, '0);
      send_cmd(tpc_pkg::OP_TICK, 32'h0001_0000);
      send_cmd(tpc_pkg::OP_PLAY, '0);
      send_cmd(tpc_pkg::OP_TICK, '1);
      send_cmd(tpc_pkg::OP_SEEK, '0);
      send_cmd(tpc_pkg::OP_SEEK, '1);
      send_cmd(tpc_pkg::OP_APPEND, '0);
      send_cmd(tpc_pkg::OP_SEEK, 32'h0003_0000);
      send_cmd(tpc_pkg::OP_STOP, '0);
      send_cmd(tpc_pkg::OP_CLEAR, '1);
      send_cmd(tpc_pkg::OP_APPEND, '1);
      send_cmd(tpc_pkg::OP_PLAY, '0);
      send_cmd(tpc_pkg::OP_TICK, 32'h0000_0001);

      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 1)
            calm_phase = 1'b1;
         drain();
         write_regs(speed_plan[ph], loop_plan[ph]);
         play_session(70);
         if (ph == 6) begin
            // full table: drops on overflow, scans over every entry
            send_cmd(tpc_pkg::OP_CLEAR, $urandom);
            stamp = $urandom_range(0, 32'h0001_0000);
            repeat (TABLE_DEPTH + 3) begin
               send_cmd(tpc_pkg::OP_APPEND, stamp);
               stamp = stamp + $urandom_range(0, 32'h0000_1000);
            end
            send_cmd(tpc_pkg::OP_PLAY, $urandom);
            repeat (4) send_cmd(tpc_pkg::OP_TICK, tick_delta());
            send_cmd(tpc_pkg::OP_SEEK, '1);
            send_cmd(tpc_pkg::OP_SEEK, $urandom_range(0, stamp));
            send_cmd(tpc_pkg::OP_TICK, '1);
            send_cmd(tpc_pkg::OP_PAUSE, $urandom);
            send_cmd(tpc_pkg::OP_PLAY, $urandom);
            send_cmd(tpc_pkg::OP_TICK, tick_delta());
            send_cmd(tpc_pkg::OP_STOP, $urandom);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("PASS timestamp_playback_cursor_unit");
      else
         $display("FAIL timestamp_playback_cursor_unit");
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("FAIL timestamp_playback_cursor_unit");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/tpc_pkg.sv
rtl/core/tpc_if.sv
rtl/core/timestamp_playback_cursor_unit.sv
rtl/core/tpc_checker.sv
tb/tpc_cursor_checker.sv
tb/timestamp_playback_cursor_unit_tb.sv
